FILE: hdl/sbc_pkg.sv
// shared types and constants of the separator byte chunker
package sbc_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_SEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_BYTE   = 2'd2;

    // reset values of the registers
    localparam logic [BYTE_W-1:0] FIRST_SEP_RESET  = 8'd10;
    localparam logic [BYTE_W-1:0] SECOND_SEP_RESET = 8'd0;

    // input command codes
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              chunk_last;
        logic              end_of_stream;
    } res_item_t;

endpackage

FILE: hdl/sbc_item_if.sv
// input channel: data bytes and end-of-stream commands
interface sbc_item_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [sbc_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

FILE: hdl/sbc_result_if.sv
// output channel: chunk bytes with last and end-of-stream marks
interface sbc_result_if;
    logic                      valid;
    logic                      ready;
    logic [sbc_pkg::BYTE_W-1:0] out_byte;
    logic                      byte_valid;
    logic                      chunk_last;
    logic                      end_of_stream;

    modport source (output valid, output out_byte, output byte_valid, output chunk_last,
                    output end_of_stream, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input chunk_last,
                    input end_of_stream, output ready);
endinterface

FILE: hdl/sbc_cfg_if.sv
// configuration write channel
interface sbc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sbc_pkg::CFG_IDX_W-1:0]  index;
    logic [sbc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/separator_byte_chunker.sv
// separator byte chunker top level
//
//  channel   direction   carries
//  item      in          cmd, data_byte
//  result    out         out_byte, byte_valid, chunk_last, end_of_stream
//  cfg       in          index, data (register write)
//
// one item beat is taken per cycle while item.ready is high; its zero to two results go
// into a four-entry result queue that drains one beat per cycle while result.ready is
// high. item.ready is high while at least two queue slots are free. cfg.ready is
// always high. rst_n sets the registers to their reset values and clears held byte,
// chunk count and queue pointers asynchronously. a stalled result side fills the
// queue and then holds item.ready low.
module separator_byte_chunker #(
    parameter int CHUNK_MAX = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    sbc_item_if.sink      item,
    sbc_result_if.source  result,
    sbc_cfg_if.sink       cfg
);

    localparam int CNT_W = $clog2(CHUNK_MAX);

    logic [sbc_pkg::BYTE_W-1:0] first_sep_reg;
    logic [sbc_pkg::BYTE_W-1:0] second_sep_reg;
    logic                       two_byte_reg;

    logic [sbc_pkg::BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic                       held_valid_reg, held_valid_next;
    logic [CNT_W-1:0]           chunk_cnt_reg, chunk_cnt_next;

    sbc_pkg::res_item_t         res_mem [sbc_pkg::RES_DEPTH];
    logic [sbc_pkg::RES_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [sbc_pkg::RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    sbc_pkg::res_item_t res0, res1, byte_res;
    logic [1:0]         n_res;
    logic               byte_emit;
    logic               full;
    logic               pair_done;
    logic               item_acc;
    logic               res_pop;
    logic [CNT_W-1:0]   cnt_inc;

    assign item.ready = (res_cnt_reg <= sbc_pkg::RES_CNT_W'(sbc_pkg::RES_DEPTH - 2));
    assign item_acc   = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid         = (res_cnt_reg != '0);
    assign result.out_byte      = res_mem[rd_ptr_reg].out_byte;
    assign result.byte_valid    = res_mem[rd_ptr_reg].byte_valid;
    assign result.chunk_last    = res_mem[rd_ptr_reg].chunk_last;
    assign result.end_of_stream = res_mem[rd_ptr_reg].end_of_stream;
    assign res_pop              = result.valid && result.ready;

    assign full      = (chunk_cnt_reg == CNT_W'(CHUNK_MAX - 1));
    assign cnt_inc   = chunk_cnt_reg + 1'b1;
    assign pair_done = held_valid_reg && two_byte_reg && (held_byte_reg == first_sep_reg)
                       && (item.data_byte == second_sep_reg);

    always_comb
    begin
        res0            = '0;
        res1            = '0;
        byte_res        = '0;
        byte_emit       = 1'b0;
        n_res           = 2'd0;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        chunk_cnt_next  = chunk_cnt_reg;

        if (item.cmd == sbc_pkg::CMD_EOS)
        begin
            res0.out_byte      = held_valid_reg ? held_byte_reg : '0;
            res0.byte_valid    = held_valid_reg;
            res0.chunk_last    = 1'b1;
            res1.chunk_last    = 1'b1;
            res1.end_of_stream = 1'b1;
            n_res              = 2'd2;
            held_byte_next     = '0;
            held_valid_next    = 1'b0;
            chunk_cnt_next     = '0;
        end
        else if (pair_done)
        begin
            res0.out_byte   = held_byte_reg;
            res0.byte_valid = 1'b1;
            res1.out_byte   = item.data_byte;
            res1.byte_valid = 1'b1;
            res1.chunk_last = 1'b1;
            n_res           = 2'd2;
            held_valid_next = 1'b0;
            chunk_cnt_next  = '0;
        end
        else
        begin
            byte_res.out_byte   = item.data_byte;
            byte_res.byte_valid = 1'b1;
            held_valid_next     = 1'b0;
            if (full)
            begin
                byte_res.chunk_last = 1'b1;
                byte_emit           = 1'b1;
                chunk_cnt_next      = '0;
            end
            else if (item.data_byte == first_sep_reg)
            begin
                // pair mode keeps a possible first separator back
                if (two_byte_reg)
                begin
                    held_byte_next  = item.data_byte;
                    held_valid_next = 1'b1;
                    chunk_cnt_next  = cnt_inc;
                end
                else
                begin
                    byte_res.chunk_last = 1'b1;
                    byte_emit           = 1'b1;
                    chunk_cnt_next      = '0;
                end
            end
            else
            begin
                byte_emit      = 1'b1;
                chunk_cnt_next = cnt_inc;
            end

            // a released held byte goes out first, never as last
            if (held_valid_reg)
            begin
                res0.out_byte   = held_byte_reg;
                res0.byte_valid = 1'b1;
                res1            = byte_res;
                n_res           = byte_emit ? 2'd2 : 2'd1;
            end
            else
            begin
                res0  = byte_res;
                n_res = byte_emit ? 2'd1 : 2'd0;
            end
        end
    end

    always_comb
    begin
        res_cnt_next = res_cnt_reg + sbc_pkg::RES_CNT_W'(item_acc ? n_res : 2'd0)
                       - sbc_pkg::RES_CNT_W'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sep_reg  <= sbc_pkg::FIRST_SEP_RESET;
            second_sep_reg <= sbc_pkg::SECOND_SEP_RESET;
            two_byte_reg   <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                sbc_pkg::REG_FIRST_SEP:  first_sep_reg  <= cfg.data;
                sbc_pkg::REG_SECOND_SEP: second_sep_reg <= cfg.data;
                sbc_pkg::REG_TWO_BYTE:   two_byte_reg   <= cfg.data[0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            chunk_cnt_reg  <= '0;
        end
        else if (item_acc)
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            chunk_cnt_reg  <= chunk_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            if (item_acc)
            begin
                wr_ptr_reg <= wr_ptr_reg + sbc_pkg::RES_PTR_W'(n_res);
            end
            if (res_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (item_acc && (n_res != 2'd0))
        begin
            res_mem[wr_ptr_reg] <= res0;
        end
        if (item_acc && (n_res == 2'd2))
        begin
            res_mem[wr_ptr_reg + 1'b1] <= res1;
        end
    end

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= sbc_pkg::RES_CNT_W'(sbc_pkg::RES_DEPTH))
        else $error("result queue overfilled");

    a_held_counted: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (chunk_cnt_reg != '0))
        else $error("held byte not counted in chunk");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && (item.cmd == sbc_pkg::CMD_EOS))
        |=> (!held_valid_reg && (chunk_cnt_reg == '0) && (res_cnt_reg != '0)))
        else $error("end of stream did not clear state");

    a_eos_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.end_of_stream) |-> (result.chunk_last && !result.byte_valid))
        else $error("malformed end-of-stream beat");
`endif

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench of the separator byte chunker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHUNK_MAX  = 256;
    localparam int STALL_MAX  = 3000;
    localparam int HOLD_BEATS = 60;

    logic clk;
    logic rst_n;

    sbc_item_if   item_ch ();
    sbc_result_if res_ch ();
    sbc_cfg_if    cfg_ch ();

    separator_byte_chunker #(
        .CHUNK_MAX (CHUNK_MAX)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // predictor copy of registers and chunk state
    logic [sbc_pkg::BYTE_W-1:0] sep_first;
    logic [sbc_pkg::BYTE_W-1:0] sep_second;
    logic                       pair_mode;
    logic [sbc_pkg::BYTE_W-1:0] held_b;
    logic                       held_vld;
    int                         fill_cnt;

    sbc_pkg::res_item_t chunk_beats_due[$];
    sbc_pkg::res_item_t want;

    int  mismatch_cnt;
    int  beats_seen;
    int  idle_cycles;
    int  send_gap_pct;
    int  recv_gap_pct;
    int  hold_left;
    bit  hold_req;

    always #5 clk = ~clk;

    function automatic void expect_beat(logic [sbc_pkg::BYTE_W-1:0] b, logic bv, logic last,
                                        logic eos);
        chunk_beats_due.push_back(sbc_pkg::res_item_t'{b, bv, last, eos});
    endfunction

    function automatic void predict_chunk_beats(logic c, logic [sbc_pkg::BYTE_W-1:0] b);
        logic [sbc_pkg::BYTE_W-1:0] h;
        logic                       full;
        if (c == sbc_pkg::CMD_EOS)
        begin
            if (held_vld)
                expect_beat(held_b, 1'b1, 1'b1, 1'b0);
            else
                expect_beat('0, 1'b0, 1'b1, 1'b0);
            expect_beat('0, 1'b0, 1'b1, 1'b1);
            held_b   = '0;
            held_vld = 1'b0;
            fill_cnt = 0;
            return;
        end
        fill_cnt++;
        full = (fill_cnt >= CHUNK_MAX);
        if (held_vld)
        begin
            h        = held_b;
            held_b   = '0;
            held_vld = 1'b0;
            expect_beat(h, 1'b1, 1'b0, 1'b0);
            if (pair_mode && h == sep_first && b == sep_second)
            begin
                expect_beat(b, 1'b1, 1'b1, 1'b0);
                fill_cnt = 0;
                return;
            end
        end
        if (pair_mode)
        begin
            if (full)
            begin
                expect_beat(b, 1'b1, 1'b1, 1'b0);
                fill_cnt = 0;
            end
            else if (b == sep_first)
            begin
                held_b   = b;
                held_vld = 1'b1;
            end
            else
                expect_beat(b, 1'b1, 1'b0, 1'b0);
        end
        else if (full || b == sep_first)
        begin
            expect_beat(b, 1'b1, 1'b1, 1'b0);
            fill_cnt = 0;
        end
        else
            expect_beat(b, 1'b1, 1'b0, 1'b0);
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        mismatch_cnt++;
        $display("mismatch: %s on result beat %0d, got %0h want %0h",
                 what, beats_seen, got, exp_val);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            beats_seen++;
            if (chunk_beats_due.size() == 0)
                report_mismatch("unexpected beat", res_ch.out_byte, 0);
            else
            begin
                want = chunk_beats_due.pop_front();
                if (res_ch.out_byte !== want.out_byte)
                    report_mismatch("out_byte", res_ch.out_byte, want.out_byte);
                if (res_ch.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", res_ch.byte_valid, want.byte_valid);
                if (res_ch.chunk_last !== want.chunk_last)
                    report_mismatch("chunk_last", res_ch.chunk_last, want.chunk_last);
                if (res_ch.end_of_stream !== want.end_of_stream)
                    report_mismatch("end_of_stream", res_ch.end_of_stream,
                                    want.end_of_stream);
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_BEATS;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_MAX)
            begin
                $display("timeout: no beat for %0d cycles", STALL_MAX);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_item(logic c, logic [sbc_pkg::BYTE_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.cmd       <= c;
        item_ch.data_byte <= b;
        do @(posedge clk); while (!item_ch.ready);
        predict_chunk_beats(c, b);
    endtask

    task automatic send_byte(logic [sbc_pkg::BYTE_W-1:0] b);
        send_item(sbc_pkg::CMD_DATA, b);
    endtask

    task automatic send_eos();
        send_item(sbc_pkg::CMD_EOS, sbc_pkg::BYTE_W'($urandom));
    endtask

    // stop offering items and let every expected beat come out
    task automatic drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (chunk_beats_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [sbc_pkg::CFG_IDX_W-1:0] idx,
                             logic [sbc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            sbc_pkg::REG_FIRST_SEP:  sep_first  = val;
            sbc_pkg::REG_SECOND_SEP: sep_second = val;
            sbc_pkg::REG_TWO_BYTE:   pair_mode  = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_mode(logic pair, logic [sbc_pkg::BYTE_W-1:0] s1,
                            logic [sbc_pkg::BYTE_W-1:0] s2);
        drain_results();
        write_reg(sbc_pkg::REG_FIRST_SEP, s1);
        write_reg(sbc_pkg::REG_SECOND_SEP, s2);
        write_reg(sbc_pkg::REG_TWO_BYTE, sbc_pkg::CFG_DATA_W'(pair));
    endtask

    function automatic logic [sbc_pkg::BYTE_W-1:0] filler_byte();
        logic [sbc_pkg::BYTE_W-1:0] b;
        do b = sbc_pkg::BYTE_W'($urandom); while (b == sep_first);
        return b;
    endfunction

    function automatic logic [sbc_pkg::BYTE_W-1:0] pick_sep();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return sbc_pkg::BYTE_W'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        // single byte mode with reset separator
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sbc_pkg::FIRST_SEP_RESET);
        send_eos();                 // empty chunk at end of stream
        send_byte(8'h41);
        send_eos();
        // pair mode
        set_mode(1'b1, 8'hFF, 8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);           // broken pair releases the held byte
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_eos();                 // held byte closes the chunk
        send_byte(8'h00);
        // mode switched back while a byte is held
        send_byte(8'hFF);
        drain_results();
        write_reg(sbc_pkg::REG_TWO_BYTE, '0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_eos();
        drain_results();
        write_reg(sbc_pkg::REG_FIRST_SEP, 8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_eos();
    endtask

    task automatic test_single_limit();
        set_mode(1'b0, sbc_pkg::FIRST_SEP_RESET, sbc_pkg::SECOND_SEP_RESET);
        repeat (CHUNK_MAX + 2) send_byte(filler_byte());
        send_eos();
    endtask

    task automatic test_pair_limit();
        set_mode(1'b1, 8'hA5, 8'h5A);
        // start from an empty chunk whatever the last segment left open
        send_eos();
        // held byte at the second-to-last slot, then a byte that breaks the pair
        repeat (CHUNK_MAX - 2) send_byte(filler_byte());
        send_byte(sep_first);
        send_byte(8'h00);
        // first byte of a pair lands on the last slot and ends the chunk
        repeat (CHUNK_MAX - 1) send_byte(filler_byte());
        send_byte(sep_first);
        send_byte(sep_second);
        send_eos();
    endtask

    task automatic test_random(int n_items);
        int                         sent;
        int                         seg_len;
        int                         r;
        logic [sbc_pkg::BYTE_W-1:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(1) == 0)
            begin
                drain_results();
                if ($urandom_range(2) != 0)
                    write_reg(sbc_pkg::REG_FIRST_SEP, pick_sep());
                if ($urandom_range(2) != 0)
                    write_reg(sbc_pkg::REG_SECOND_SEP,
                              ($urandom_range(4) == 0) ? sep_first : pick_sep());
                if ($urandom_range(2) != 0)
                    write_reg(sbc_pkg::REG_TWO_BYTE,
                              sbc_pkg::CFG_DATA_W'($urandom_range(1)));
            end
            seg_len = $urandom_range(8, 48);
            repeat (seg_len)
            begin
                r = $urandom_range(99);
                if (r < 4)
                    send_eos();
                else
                begin
                    if (r < 34)
                        b = sep_first;
                    else if (r < 56)
                        b = sep_second;
                    else if (r < 62)
                        b = sep_first ^ (8'h01 << $urandom_range(7));
                    else
                        b = sbc_pkg::BYTE_W'($urandom);
                    send_byte(b);
                end
                sent++;
            end
            // some segments stay open so a held byte meets a register change
            if ($urandom_range(3) != 0)
            begin
                send_eos();
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        set_mode(1'b1, 8'h0D, 8'h0A);
        hold_req = 1'b1;
        repeat (30)
            send_byte(($urandom_range(2) == 0) ? sep_first : sbc_pkg::BYTE_W'($urandom));
        send_eos();
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.cmd       = sbc_pkg::CMD_DATA;
        item_ch.data_byte = '0;
        res_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = sbc_pkg::REG_FIRST_SEP;
        cfg_ch.data       = '0;
        sep_first         = sbc_pkg::FIRST_SEP_RESET;
        sep_second        = sbc_pkg::SECOND_SEP_RESET;
        pair_mode         = 1'b0;
        held_b            = '0;
        held_vld          = 1'b0;
        fill_cnt          = 0;
        mismatch_cnt      = 0;
        beats_seen        = 0;
        idle_cycles       = 0;
        hold_left         = 0;
        hold_req          = 1'b0;
        send_gap_pct      = 7;
        recv_gap_pct      = 46;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_single_limit();
        test_random(40);

        send_gap_pct = 46;
        recv_gap_pct = 7;
        test_pair_limit();
        test_random(40);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random(40);
        test_backpressure();
        test_random(40);

        drain_results();
        if (mismatch_cnt == 0 && chunk_beats_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
